// ===== rtl/lhs_pkg.sv =====
// lhs_pkg: shared types and constants of the lane histogram steering core
// register indexes, reset values, field widths, steering codes, sequencer states
// no dependencies
package lhs_pkg;

    localparam int FRAME_WIDTH_DEF  = 360;
    localparam int FRAME_HEIGHT_DEF = 240;

    localparam int COL_W    = 9;
    localparam int ROW_W    = 8;
    localparam int CNT_W    = 8;
    localparam int POS_W    = 9;
    localparam int OFFSET_W = 10;
    localparam int CODE_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 40;

    localparam logic [CFG_IDX_W-1:0] REG_ROI_TOP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_ROWS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_START  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_CENTER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_STEP    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_STEP     = 3'd6;

    localparam logic [7:0] ROI_TOP_RST      = 8'd140;
    localparam logic [7:0] ROI_ROWS_RST     = 8'd100;
    localparam logic [8:0] LEFT_LIMIT_RST   = 9'd160;
    localparam logic [8:0] RIGHT_START_RST  = 9'd200;
    localparam logic [8:0] FRAME_CENTER_RST = 9'd180;
    localparam logic [8:0] NEAR_STEP_RST    = 9'd10;
    localparam logic [8:0] FAR_STEP_RST     = 9'd20;

    localparam logic [CODE_W-1:0] STEER_FWD     = 3'd0;
    localparam logic [CODE_W-1:0] STEER_RIGHT_1 = 3'd1;
    localparam logic [CODE_W-1:0] STEER_RIGHT_2 = 3'd2;
    localparam logic [CODE_W-1:0] STEER_RIGHT_3 = 3'd3;
    localparam logic [CODE_W-1:0] STEER_LEFT_1  = 3'd4;
    localparam logic [CODE_W-1:0] STEER_LEFT_2  = 3'd5;
    localparam logic [CODE_W-1:0] STEER_LEFT_3  = 3'd6;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_LSCAN,
        ST_LDRAIN,
        ST_RSCAN,
        ST_RDRAIN,
        ST_HALF,
        ST_CENTER,
        ST_DIFF,
        ST_RESULT
    } lhs_state_t;

endpackage

// ===== rtl/lhs_ram.sv =====
// lhs_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
module lhs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 360
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/lane_histogram_steering_core.sv =====
// lane_histogram_steering_core: column histogram of binary pixels, peak search
// and seven-level steering code; uses lhs_pkg and lhs_ram
// Pixels arrive with column and row; white pixels inside the row band add one
// to a saturating 8-bit count per column, kept in one RAM of FRAME_WIDTH
// entries. Each pixel is a RAM read issued on acceptance followed by the
// write-back of the incremented count, and no new pixel is taken in between,
// since the single memory carries one read-modify-write at a time. On the
// end-of-frame pixel the sequencer scans the left range and then the right
// range through the RAM read port with one shared compare, skipping a range
// that is empty, then computes the half span, the midpoint and the offset in
// turn, forms the steering code as it loads the result register (waiting only
// if the previous result is still untaken) and clears the histogram one entry
// per cycle. The same clearing pass runs after reset; s_tready is low
// throughout, while configuration writes are taken at any time.
module lane_histogram_steering_core #(
    parameter int FRAME_WIDTH  = lhs_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = lhs_pkg::FRAME_HEIGHT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // pixel stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lhs_pkg::S_TDATA_W-1:0]   s_tdata,   // column[8:0], row[16:9], zero pad
    input  logic [0:0]                      s_tuser,   // white[0]
    input  logic                            s_tlast,   // end of frame
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lhs_pkg::M_TDATA_W-1:0]   m_tdata,   // left_pos[8:0], right_pos[17:9],
                                                       // center_pos[26:18], offset[36:27],
                                                       // steer_code[39:37]
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [lhs_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [lhs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int AW = $clog2(FRAME_WIDTH);
    localparam int PW = (AW + 1 > 10) ? AW + 1 : 10;

    localparam logic [PW-1:0]       FW_P     = PW'(FRAME_WIDTH);
    localparam logic [AW-1:0]       LAST_COL = AW'(FRAME_WIDTH - 1);
    localparam logic signed [PW:0]  OFF_MAX  = (PW+1)'(511);
    localparam logic signed [PW:0]  OFF_MIN  = -OFF_MAX - (PW+1)'(1);

    lhs_pkg::lhs_state_t state_reg, state_next;

    // configuration registers
    logic [7:0] roi_top_reg, roi_rows_reg;
    logic [8:0] left_limit_reg, right_start_reg, frame_center_reg;
    logic [8:0] near_step_reg, far_step_reg;

    // pixel in flight
    logic          count_reg, count_next;
    logic          eof_reg, eof_next;
    logic [AW-1:0] pix_addr_reg, pix_addr_next;

    // scan
    logic [AW-1:0]           scan_reg, scan_next;
    logic [AW-1:0]           last_reg, last_next;
    logic                    pend_reg, pend_next;
    logic [AW-1:0]           pend_addr_reg, pend_addr_next;
    logic                    first_reg, first_next;
    logic [lhs_pkg::CNT_W-1:0] best_cnt_reg, best_cnt_next;
    logic [AW-1:0]           best_addr_reg, best_addr_next;

    // arithmetic
    logic [PW-1:0]       left_pos_reg, left_pos_next;
    logic [PW-1:0]       right_pos_reg, right_pos_next;
    logic signed [PW:0]  half_reg, half_next;
    logic [PW-1:0]       center_reg, center_next;
    logic signed [PW:0]  diff_reg, diff_next;

    // result and clearing
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [lhs_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [AW-1:0]                 clr_reg, clr_next;

    // ram ports
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [lhs_pkg::CNT_W-1:0] ram_wdata;
    logic [AW-1:0]             ram_raddr;
    logic [lhs_pkg::CNT_W-1:0] ram_rdata;

    // combinational helpers
    logic [lhs_pkg::COL_W-1:0] in_col;
    logic [lhs_pkg::ROW_W-1:0] in_row;
    logic                      in_col_ok;
    logic                      in_row_ok;
    logic [8:0]                band_end;
    logic                      take;
    logic [AW-1:0]             peak_addr;
    logic [PW-1:0]             lim;
    logic                      right_empty;
    logic signed [PW:0]        span;
    logic signed [PW:0]        center_sum;
    logic signed [PW:0]        n_s, f_s;
    logic signed [PW:0]        off_sat;
    logic [lhs_pkg::CODE_W-1:0] code;

    lhs_ram #(
        .WIDTH(lhs_pkg::CNT_W),
        .DEPTH(FRAME_WIDTH)
    ) u_hist_ram (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    assign s_tready = (state_reg == lhs_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            roi_top_reg      <= lhs_pkg::ROI_TOP_RST;
            roi_rows_reg     <= lhs_pkg::ROI_ROWS_RST;
            left_limit_reg   <= lhs_pkg::LEFT_LIMIT_RST;
            right_start_reg  <= lhs_pkg::RIGHT_START_RST;
            frame_center_reg <= lhs_pkg::FRAME_CENTER_RST;
            near_step_reg    <= lhs_pkg::NEAR_STEP_RST;
            far_step_reg     <= lhs_pkg::FAR_STEP_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                lhs_pkg::REG_ROI_TOP:      roi_top_reg      <= cfg_wdata[7:0];
                lhs_pkg::REG_ROI_ROWS:     roi_rows_reg     <= cfg_wdata[7:0];
                lhs_pkg::REG_LEFT_LIMIT:   left_limit_reg   <= cfg_wdata;
                lhs_pkg::REG_RIGHT_START:  right_start_reg  <= cfg_wdata;
                lhs_pkg::REG_FRAME_CENTER: frame_center_reg <= cfg_wdata;
                lhs_pkg::REG_NEAR_STEP:    near_step_reg    <= cfg_wdata;
                lhs_pkg::REG_FAR_STEP:     far_step_reg     <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lhs_pkg::ST_CLEAR;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            clr_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
            clr_reg      <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        count_reg     <= count_next;
        eof_reg       <= eof_next;
        pix_addr_reg  <= pix_addr_next;
        scan_reg      <= scan_next;
        last_reg      <= last_next;
        pend_addr_reg <= pend_addr_next;
        first_reg     <= first_next;
        best_cnt_reg  <= best_cnt_next;
        best_addr_reg <= best_addr_next;
        left_pos_reg  <= left_pos_next;
        right_pos_reg <= right_pos_next;
        half_reg      <= half_next;
        center_reg    <= center_next;
        diff_reg      <= diff_next;
        m_tdata_reg   <= m_tdata_next;
    end

    always_comb begin
        in_col    = s_tdata[lhs_pkg::COL_W-1:0];
        in_row    = s_tdata[lhs_pkg::COL_W +: lhs_pkg::ROW_W];
        in_col_ok = 32'(in_col) < FRAME_WIDTH;
        band_end  = 9'(roi_top_reg) + 9'(roi_rows_reg);
        in_row_ok = (32'(in_row) < FRAME_HEIGHT) && (in_row >= roi_top_reg)
                    && (9'(in_row) < band_end);

        // shared compare: lowest column with the highest count wins
        take      = first_reg || (ram_rdata > best_cnt_reg);
        peak_addr = take ? pend_addr_reg : best_addr_reg;

        lim         = (PW'(left_limit_reg) > FW_P) ? FW_P : PW'(left_limit_reg);
        right_empty = PW'(right_start_reg) >= FW_P;

        span       = $signed({1'b0, right_pos_reg}) - $signed({1'b0, left_pos_reg});
        center_sum = $signed({1'b0, left_pos_reg}) + half_reg;

        n_s = $signed({1'b0, PW'(near_step_reg)});
        f_s = $signed({1'b0, PW'(far_step_reg)});

        off_sat = (diff_reg > OFF_MAX) ? OFF_MAX : ((diff_reg < OFF_MIN) ? OFF_MIN : diff_reg);

        if (diff_reg == '0) begin
            code = lhs_pkg::STEER_FWD;
        end else if (diff_reg > 0 && diff_reg < n_s) begin
            code = lhs_pkg::STEER_RIGHT_1;
        end else if (diff_reg >= n_s && diff_reg < f_s) begin
            code = lhs_pkg::STEER_RIGHT_2;
        end else if (diff_reg >= f_s) begin
            code = lhs_pkg::STEER_RIGHT_3;
        end else if (diff_reg < 0 && diff_reg > -n_s) begin
            code = lhs_pkg::STEER_LEFT_1;
        end else if (diff_reg <= -n_s && diff_reg > -f_s) begin
            code = lhs_pkg::STEER_LEFT_2;
        end else begin
            code = lhs_pkg::STEER_LEFT_3;
        end
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        eof_next       = eof_reg;
        pix_addr_next  = pix_addr_reg;
        scan_next      = scan_reg;
        last_next      = last_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        first_next     = first_reg;
        best_cnt_next  = best_cnt_reg;
        best_addr_next = best_addr_reg;
        left_pos_next  = left_pos_reg;
        right_pos_next = right_pos_reg;
        half_next      = half_reg;
        center_next    = center_reg;
        diff_next      = diff_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        clr_next       = clr_reg;

        ram_we    = 1'b0;
        ram_waddr = pix_addr_reg;
        ram_wdata = 8'(ram_rdata + 8'd1);
        ram_raddr = scan_reg;

        // compare step for the read issued in the previous cycle
        if (pend_reg) begin
            first_next = 1'b0;
            if (take) begin
                best_cnt_next  = ram_rdata;
                best_addr_next = pend_addr_reg;
            end
        end

        case (state_reg)
            lhs_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = AW'(clr_reg + 1'b1);
                if (clr_reg == LAST_COL) begin
                    state_next = lhs_pkg::ST_IDLE;
                end
            end
            lhs_pkg::ST_IDLE: begin
                pix_addr_next = in_col_ok ? AW'(in_col) : '0;
                ram_raddr     = pix_addr_next;
                if (s_tvalid) begin
                    count_next = s_tuser[0] && in_col_ok && in_row_ok;
                    eof_next   = s_tlast;
                    state_next = lhs_pkg::ST_UPDATE;
                end
            end
            lhs_pkg::ST_UPDATE: begin
                ram_we = count_reg && (ram_rdata != 8'hFF);
                if (!eof_reg) begin
                    state_next = lhs_pkg::ST_IDLE;
                end else if (lim == '0) begin
                    left_pos_next = '0;
                    if (right_empty) begin
                        right_pos_next = FW_P - PW'(1);
                        state_next     = lhs_pkg::ST_HALF;
                    end else begin
                        scan_next  = AW'(right_start_reg);
                        last_next  = LAST_COL;
                        first_next = 1'b1;
                        state_next = lhs_pkg::ST_RSCAN;
                    end
                end else begin
                    scan_next  = '0;
                    last_next  = AW'(lim - PW'(1));
                    first_next = 1'b1;
                    state_next = lhs_pkg::ST_LSCAN;
                end
            end
            lhs_pkg::ST_LSCAN, lhs_pkg::ST_RSCAN: begin
                pend_next      = 1'b1;
                pend_addr_next = scan_reg;
                scan_next      = AW'(scan_reg + 1'b1);
                if (scan_reg == last_reg) begin
                    state_next = (state_reg == lhs_pkg::ST_LSCAN) ? lhs_pkg::ST_LDRAIN
                                                                  : lhs_pkg::ST_RDRAIN;
                end
            end
            lhs_pkg::ST_LDRAIN: begin
                left_pos_next = PW'(peak_addr);
                if (right_empty) begin
                    right_pos_next = FW_P - PW'(1);
                    state_next     = lhs_pkg::ST_HALF;
                end else begin
                    scan_next  = AW'(right_start_reg);
                    last_next  = LAST_COL;
                    first_next = 1'b1;
                    state_next = lhs_pkg::ST_RSCAN;
                end
            end
            lhs_pkg::ST_RDRAIN: begin
                right_pos_next = PW'(peak_addr);
                state_next     = lhs_pkg::ST_HALF;
            end
            lhs_pkg::ST_HALF: begin
                // halve toward zero: add one before the shift when negative
                half_next  = (span + $signed({{PW{1'b0}}, span[PW]})) >>> 1;
                state_next = lhs_pkg::ST_CENTER;
            end
            lhs_pkg::ST_CENTER: begin
                center_next = center_sum[PW-1:0];
                state_next  = lhs_pkg::ST_DIFF;
            end
            lhs_pkg::ST_DIFF: begin
                diff_next  = $signed({1'b0, center_reg})
                             - $signed({1'b0, PW'(frame_center_reg)});
                state_next = lhs_pkg::ST_RESULT;
            end
            lhs_pkg::ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {code, off_sat[lhs_pkg::OFFSET_W-1:0],
                                     center_reg[lhs_pkg::POS_W-1:0],
                                     right_pos_reg[lhs_pkg::POS_W-1:0],
                                     left_pos_reg[lhs_pkg::POS_W-1:0]};
                    clr_next      = '0;
                    state_next    = lhs_pkg::ST_CLEAR;
                end
            end
            default: begin
                state_next = lhs_pkg::ST_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

endmodule

// ===== sim/lane_histogram_steering_checker.sv =====
// lane_histogram_steering_checker: watches the pixel, result and register ports of the
// lane histogram steering core, predicts each steering result and compares it
// depends on lhs_pkg
module lane_histogram_steering_checker #(
    parameter int FRAME_WIDTH  = lhs_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = lhs_pkg::FRAME_HEIGHT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [lhs_pkg::S_TDATA_W-1:0]   s_tdata,   // column[8:0], row[16:9], zero pad
    input  logic [0:0]                      s_tuser,   // white[0]
    input  logic                            s_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [lhs_pkg::M_TDATA_W-1:0]   m_tdata,   // left_pos[8:0], right_pos[17:9],
                                                       // center_pos[26:18], offset[36:27],
                                                       // steer_code[39:37]
    input  logic                            cfg_wr_en,
    input  logic [lhs_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [lhs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                              pending_steers,
    output int                              mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import lhs_pkg::*;

    localparam int LP_LO   = 0;
    localparam int RP_LO   = POS_W;
    localparam int CP_LO   = 2 * POS_W;
    localparam int OFF_LO  = 3 * POS_W;
    localparam int CODE_LO = OFF_LO + OFFSET_W;

    typedef struct packed {
        logic [POS_W-1:0]    left_pos;
        logic [POS_W-1:0]    right_pos;
        logic [POS_W-1:0]    center_pos;
        logic [OFFSET_W-1:0] offset;
        logic [CODE_W-1:0]   steer_code;
    } steer_result_t;

    logic [CNT_W-1:0] hist [FRAME_WIDTH];
    logic [7:0]       band_top, band_rows;
    logic [8:0]       left_edge, right_edge, center_col, near_lvl, far_lvl;
    steer_result_t    expected_steers [$];

    initial begin
        pending_steers = 0;
        mismatch_count = 0;
    end

    function automatic int peak_column(int lo, int hi);
        int best;
        best = lo;
        for (int c = lo + 1; c < hi; c++)
            if (hist[c] > hist[best])
                best = c;
        return best;
    endfunction

    always @(posedge aclk) begin : watch
        int lim, lpos, rpos, mid, diff, clipped, n, f;
        logic [COL_W-1:0] px_col;
        logic [ROW_W-1:0] px_row;
        steer_result_t want, got;

        if (!aresetn) begin
            expected_steers.delete();
            for (int c = 0; c < FRAME_WIDTH; c++)
                hist[c] = '0;
            band_top   = ROI_TOP_RST;
            band_rows  = ROI_ROWS_RST;
            left_edge  = LEFT_LIMIT_RST;
            right_edge = RIGHT_START_RST;
            center_col = FRAME_CENTER_RST;
            near_lvl   = NEAR_STEP_RST;
            far_lvl    = FAR_STEP_RST;
        end else begin
            // results first, so a result cannot be matched against the frame closing now
            if (m_tvalid && m_tready) begin
                got.left_pos   = m_tdata[LP_LO +: POS_W];
                got.right_pos  = m_tdata[RP_LO +: POS_W];
                got.center_pos = m_tdata[CP_LO +: POS_W];
                got.offset     = m_tdata[OFF_LO +: OFFSET_W];
                got.steer_code = m_tdata[CODE_LO +: CODE_W];
                if (expected_steers.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("steering result with none expected: tdata %h", m_tdata);
                end else begin
                    want = expected_steers.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $write("steering mismatch: exp L%0d R%0d C%0d off %0d code %0d,",
                                   want.left_pos, want.right_pos, want.center_pos,
                                   $signed(want.offset), want.steer_code);
                            $display(" got L%0d R%0d C%0d off %0d code %0d",
                                     got.left_pos, got.right_pos, got.center_pos,
                                     $signed(got.offset), got.steer_code);
                        end
                    end
                end
            end

            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_ROI_TOP:      band_top   = cfg_wdata[7:0];
                    REG_ROI_ROWS:     band_rows  = cfg_wdata[7:0];
                    REG_LEFT_LIMIT:   left_edge  = cfg_wdata;
                    REG_RIGHT_START:  right_edge = cfg_wdata;
                    REG_FRAME_CENTER: center_col = cfg_wdata;
                    REG_NEAR_STEP:    near_lvl   = cfg_wdata;
                    REG_FAR_STEP:     far_lvl    = cfg_wdata;
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                px_col = s_tdata[COL_W-1:0];
                px_row = s_tdata[COL_W +: ROW_W];
                // the closing pixel is counted before the scan
                if (s_tuser[0] && px_col < FRAME_WIDTH && px_row < FRAME_HEIGHT &&
                    int'(px_row) >= int'(band_top) &&
                    int'(px_row) < int'(band_top) + int'(band_rows) &&
                    hist[px_col] != {CNT_W{1'b1}})
                    hist[px_col] = hist[px_col] + 1'b1;

                if (s_tlast) begin
                    lim  = (left_edge > FRAME_WIDTH) ? FRAME_WIDTH : int'(left_edge);
                    lpos = (lim == 0) ? 0 : peak_column(0, lim);
                    rpos = (right_edge >= FRAME_WIDTH) ? FRAME_WIDTH - 1
                                                       : peak_column(int'(right_edge),
                                                                     FRAME_WIDTH);
                    mid     = (rpos - lpos) / 2 + lpos;
                    diff    = mid - int'(center_col);
                    clipped = (diff > 511) ? 511 : ((diff < -512) ? -512 : diff);
                    n = int'(near_lvl);
                    f = int'(far_lvl);

                    // right side is tested first, in strict order, even with odd steps
                    if (diff == 0)
                        want.steer_code = STEER_FWD;
                    else if (diff > 0 && diff < n)
                        want.steer_code = STEER_RIGHT_1;
                    else if (diff >= n && diff < f)
                        want.steer_code = STEER_RIGHT_2;
                    else if (diff >= f)
                        want.steer_code = STEER_RIGHT_3;
                    else if (diff < 0 && diff > -n)
                        want.steer_code = STEER_LEFT_1;
                    else if (diff <= -n && diff > -f)
                        want.steer_code = STEER_LEFT_2;
                    else
                        want.steer_code = STEER_LEFT_3;

                    want.left_pos   = POS_W'(lpos);
                    want.right_pos  = POS_W'(rpos);
                    want.center_pos = POS_W'(mid);
                    want.offset     = OFFSET_W'(clipped);
                    expected_steers.insert(expected_steers.size(), want);

                    for (int c = 0; c < FRAME_WIDTH; c++)
                        hist[c] = '0;
                end
            end
        end
        pending_steers = expected_steers.size();
    end

endmodule

// ===== sim/tb_lane_histogram_steering_core.sv =====
// tb_lane_histogram_steering_core: pixel stimulus, register setup and verdict for the
// lane histogram steering core; depends on lhs_pkg, the core and lane_histogram_steering_checker
module tb_lane_histogram_steering_core;
    timeunit 1ns;
    timeprecision 1ps;
    import lhs_pkg::*;

    localparam int FRAME_WIDTH   = FRAME_WIDTH_DEF;
    localparam int FRAME_HEIGHT  = FRAME_HEIGHT_DEF;
    localparam int CLK_PERIOD    = 20;
    localparam int SETTLE_CYCLES = 3 * FRAME_WIDTH + 64;
    localparam int LONG_HOLD     = 5000;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int HOLD_PHASE    = 6;
    localparam int PAUSE_PHASE   = 7;

    typedef enum logic [1:0] {SINK_OPEN, SINK_PATTERN, SINK_RANDOM} sink_mode_t;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata   = '0;
    logic [0:0]              s_tuser   = '0;
    logic                    s_tlast   = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

    int steer_backlog, steer_mismatches;
    int burst_left  = 0;
    int items_sent  = 0;
    bit hold_wanted = 1'b0;

    // shadow of the band and search ranges, used only to shape stimulus
    int cur_top   = int'(ROI_TOP_RST);
    int cur_rows  = int'(ROI_ROWS_RST);
    int cur_left  = int'(LEFT_LIMIT_RST);
    int cur_right = int'(RIGHT_START_RST);

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    lane_histogram_steering_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    lane_histogram_steering_checker #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) steer_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .pending_steers (steer_backlog),
        .mismatch_count (steer_mismatches)
    );

    // one pixel transaction, with bursts and gaps on the sending side
    task automatic send_pixel(input int col, input int row,
                              input logic white, input logic eof);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat (($urandom_range(7) == 0) ? $urandom_range(30, 8) : $urandom_range(6, 1))
                @(negedge aclk);
            burst_left = ($urandom_range(9) == 0) ? 300 : $urandom_range(24, 1);
        end
        s_tdata  <= {{(S_TDATA_W - COL_W - ROW_W){1'b0}}, ROW_W'(row), COL_W'(col)};
        s_tuser  <= white;
        s_tlast  <= eof;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
        burst_left--;
        items_sent++;
    endtask

    task automatic wait_until_idle();
        s_tvalid <= 1'b0;
        while (steer_backlog != 0)
            @(negedge aclk);
        // the core may still be clearing its histogram after the last result
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        @(negedge aclk);
    endtask

    task automatic program_core(input int band_top, input int band_rows, input int left_lim,
                                input int right_beg, input int center, input int near_lvl,
                                input int far_lvl);
        wait_until_idle();
        write_reg(REG_ROI_TOP, band_top);
        write_reg(REG_ROI_ROWS, band_rows);
        write_reg(REG_LEFT_LIMIT, left_lim);
        write_reg(REG_RIGHT_START, right_beg);
        write_reg(REG_FRAME_CENTER, center);
        write_reg(REG_NEAR_STEP, near_lvl);
        write_reg(REG_FAR_STEP, far_lvl);
        cfg_wr_en <= 1'b0;
        cur_top   = band_top;
        cur_rows  = band_rows;
        cur_left  = left_lim;
        cur_right = right_beg;
    endtask

    // mostly lane pixels piled on one left and one right column, some noise
    task automatic send_frame(input int n_pixels);
        int lim, lpeak, rpeak, band_lo, band_hi, col, row, pick;
        logic white;
        lim     = (cur_left > FRAME_WIDTH) ? FRAME_WIDTH : cur_left;
        lpeak   = (lim > 0) ? $urandom_range(lim - 1, 0) : 0;
        rpeak   = (cur_right < FRAME_WIDTH) ? $urandom_range(FRAME_WIDTH - 1, cur_right)
                                            : FRAME_WIDTH - 1;
        band_lo = cur_top;
        band_hi = (cur_top + cur_rows > FRAME_HEIGHT) ? FRAME_HEIGHT : cur_top + cur_rows;
        for (int i = 0; i < n_pixels; i++) begin
            pick = $urandom_range(99);
            if (pick < 85 && band_hi > band_lo) begin
                white = 1'b1;
                row   = $urandom_range(band_hi - 1, band_lo);
                if (pick < 35)
                    col = lpeak;
                else if (pick < 70)
                    col = rpeak;
                else
                    col = $urandom_range(FRAME_WIDTH - 1);
            end else begin
                white = 1'($urandom_range(1));
                col   = $urandom_range((1 << COL_W) - 1);
                row   = $urandom_range((1 << ROW_W) - 1);
            end
            send_pixel(col, row, white, i == n_pixels - 1);
        end
    endtask

    initial begin : result_sink
        sink_mode_t   mode;
        int           mode_left;
        logic [15:0]  stall_pattern;
        bit           hold_done;
        mode          = SINK_OPEN;
        mode_left     = 0;
        stall_pattern = '0;
        hold_done     = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_wanted && !hold_done) begin
                // long hold-off so the core backs up and stalls the pixel stream
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                hold_done = 1'b1;
            end
            if (mode_left == 0) begin
                mode_left     = $urandom_range(200, 20);
                mode          = sink_mode_t'($urandom_range(2));
                stall_pattern = 16'($urandom);
            end
            mode_left--;
            case (mode)
                SINK_OPEN:    m_tready <= 1'b1;
                SINK_PATTERN: begin
                    m_tready <= stall_pattern[0];
                    stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
                end
                default:      m_tready <= ($urandom_range(3) != 0);
            endcase
        end
    end

    initial begin : stimulus
        int phase, pick, sat_total;
        int sat_cols [3];
        int sat_left [3];

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: band rows 140..239, left 0..159, right 200..359, center 180
        send_pixel(0, 0, 1'b0, 1'b1);                 // empty frame, every range all zero
        send_pixel(0, 140, 1'b1, 1'b0);               // first row of the band
        send_pixel(159, 139, 1'b1, 1'b0);             // row just above the band
        send_pixel(160, 200, 1'b1, 1'b0);             // column between the two ranges
        send_pixel(511, 200, 1'b1, 1'b0);             // column outside the frame
        send_pixel(100, 255, 1'b1, 1'b0);             // row outside the frame
        send_pixel(150, 239, 1'b1, 1'b0);
        send_pixel(150, 150, 1'b1, 1'b0);
        send_pixel(359, 239, 1'b1, 1'b1);             // closing pixel is still counted
        send_pixel(130, 141, 1'b1, 1'b0);             // ties in both ranges, center on target
        send_pixel(100, 239, 1'b1, 1'b0);
        send_pixel(300, 180, 1'b1, 1'b0);
        send_pixel(260, 180, 1'b1, 1'b0);
        send_pixel(359, 0, 1'b0, 1'b1);
        send_pixel(100, 180, 1'b1, 1'b0);             // small offset to the right
        send_pixel(270, 239, 1'b1, 1'b1);
        send_pixel(100, 180, 1'b1, 1'b0);             // offset equal to the near step
        send_pixel(280, 200, 1'b1, 1'b1);
        send_pixel(100, 180, 1'b1, 1'b0);             // small offset to the left
        send_pixel(250, 200, 1'b1, 1'b1);
        send_pixel(100, 180, 1'b1, 1'b0);             // left offset equal to the near step
        send_pixel(240, 200, 1'b1, 1'b1);

        sat_cols = '{30, 60, 250};
        phase = 0;
        while (phase < 8 || items_sent < 1200) begin
            case (phase)
                0: program_core(0, 240, 200, 200, 180, 10, 20);
                1: program_core(0, 240, 359, 0, 0, 1, 359);
                2: program_core(239, 240, 1, 359, 359, 359, 1);       // steps out of order
                3: program_core(200, 100, 0, 400, 511, 0, 0);         // both ranges empty
                4: program_core(100, 255, 511, 360, 180, 30, 60);     // left limit clamped
                default: program_core($urandom_range(239), $urandom_range(240, 1),
                                      $urandom_range(359, 1), $urandom_range(359),
                                      $urandom_range(359), $urandom_range(40, 1),
                                      $urandom_range(80, 1));
            endcase

            if (phase == 0) begin
                // counters pinned at full scale: the lower column of a saturated tie wins,
                // and a counter that wrapped would lose its peak
                sat_left  = '{255, 256, 256};
                sat_total = 767;
                while (sat_total > 0) begin
                    pick = $urandom_range(2);
                    if (sat_left[pick] != 0) begin
                        sat_left[pick]--;
                        sat_total--;
                        send_pixel(sat_cols[pick], $urandom_range(FRAME_HEIGHT - 1), 1'b1,
                                   sat_total == 0);
                    end
                end
            end
            if (phase == HOLD_PHASE)
                hold_wanted = 1'b1;

            for (int f = 0; f < 6; f++) begin
                if (phase == PAUSE_PHASE && f == 3)
                    wait_until_idle();
                send_frame(($urandom_range(9) == 0) ? 1 : $urandom_range(16, 4));
            end
            phase++;
        end

        wait_until_idle();
        if (steer_mismatches == 0 && steer_backlog == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin : watchdog
        #(CYCLE_LIMIT * CLK_PERIOD);
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lhs_pkg.sv
rtl/lhs_ram.sv
rtl/lane_histogram_steering_core.sv
sim/lane_histogram_steering_checker.sv
sim/tb_lane_histogram_steering_core.sv
